[rtl/hpfs_pkg.sv]
// Shared types and constants of the half-pel block frame store.
`timescale 1ns / 1ps

package hpfs_pkg;

    // Block geometry and bank layout
    localparam int BLK      = 8;
    localparam int PIX_W    = 8;
    localparam int NLANES   = 16;
    localparam int LANE_W   = 4;
    localparam int ADDR_W   = 22;
    localparam int DIM_W    = 10;
    localparam int ROW_W    = 3;
    localparam int CNT_W    = 4;
    localparam int CFG_IDX_W = 1;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    // Fetch counts: frame reads take nine source rows, field reads five
    localparam logic [CNT_W-1:0] FRAME_LAST_CNT = 4'd8;
    localparam logic [CNT_W-1:0] FIELD_LAST_CNT = 4'd4;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_FRAME = 2'd1,
        OP_FIELD = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ISSUE
    } t_state;

    // Control travelling with one fetched row or one direct result
    typedef struct packed {
        logic               vld;
        logic               direct;
        logic               fetch;
        logic               emit;
        logic               status;
        logic [ROW_W-1:0]   row;
        logic               last;
        logic               hx;
        logic               hy;
        logic [LANE_W-1:0]  rot;
    } t_tag;

endpackage

[rtl/hpfs_in_if.sv]
// Input channel of the frame store: one command beat.
`timescale 1ns / 1ps

interface hpfs_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic signed [9:0]  x_pos;
    logic signed [9:0]  y_pos;
    logic               half_x;
    logic               half_y;
    logic               field_select;
    logic [2:0]         row_index;
    logic [63:0]        row_pixels;

    modport source (
        output valid, operation, x_pos, y_pos, half_x, half_y, field_select,
               row_index, row_pixels,
        input  ready
    );

    modport sink (
        input  valid, operation, x_pos, y_pos, half_x, half_y, field_select,
               row_index, row_pixels,
        output ready
    );
endinterface

[rtl/hpfs_out_if.sv]
// Output channel of the frame store: one result beat.
`timescale 1ns / 1ps

interface hpfs_out_if;
    logic               valid;
    logic               ready;
    logic               status;
    logic [2:0]         out_row;
    logic [63:0]        out_pixels;
    logic               last;

    modport source (
        output valid, status, out_row, out_pixels, last,
        input  ready
    );

    modport sink (
        input  valid, status, out_row, out_pixels, last,
        output ready
    );
endinterface

[rtl/hpfs_lane.sv]
// One byte bank of the frame store with its own address and range logic.
`timescale 1ns / 1ps

module hpfs_lane #(
    parameter int LANE       = 0,
    parameter int DEPTH      = 262144,
    parameter int BANK_DEPTH = 16384,
    parameter int IDX_W      = 14,
    parameter int PW         = 22
) (
    input  logic                          i_clk,
    input  logic                          i_rd_en,
    input  logic                          i_wr_en,
    input  logic [PW-1:0]                 i_base,
    input  logic [hpfs_pkg::LANE_W-1:0]   i_rot,
    input  logic [63:0]                   i_wdata,
    input  logic [PW-1:0]                 i_limit,
    output logic [hpfs_pkg::PIX_W-1:0]    o_byte
);

    logic [hpfs_pkg::PIX_W-1:0] mem [0:BANK_DEPTH-1];
    logic [hpfs_pkg::PIX_W-1:0] r_rd;
    logic                       r_ok;
    logic [PW-1:0]              w_addr;
    logic [hpfs_pkg::LANE_W-1:0] w_widx;
    logic [hpfs_pkg::PIX_W-1:0] w_wbyte;
    logic                       w_store;

    // Byte address this bank serves: the aligned word, or the next one
    // when the bank sits below the starting byte
    always_comb begin
        w_addr = {i_base[PW-1:hpfs_pkg::LANE_W], hpfs_pkg::LANE_W'(LANE)};
        if (hpfs_pkg::LANE_W'(LANE) < i_rot) begin
            w_addr = w_addr + PW'(hpfs_pkg::NLANES);
        end
    end

    // Pick the write byte; only the first eight bytes of the span are stored
    assign w_widx  = hpfs_pkg::LANE_W'(LANE) - i_rot;
    assign w_wbyte = i_wdata[8*w_widx[2:0] +: 8];
    assign w_store = i_wr_en && !w_widx[hpfs_pkg::LANE_W-1] && (w_addr < PW'(DEPTH));

    // Bank port: one write or one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_store) begin
            mem[w_addr[hpfs_pkg::LANE_W +: IDX_W]] <= w_wbyte;
        end
        if (i_rd_en) begin
            r_rd <= mem[w_addr[hpfs_pkg::LANE_W +: IDX_W]];
            r_ok <= (w_addr < i_limit);
        end
    end

    // Bytes past the frame read as zero
    assign o_byte = r_ok ? r_rd : '0;

endmodule

[rtl/hpfs_merge.sv]
// Merging stage: realigns the bank bytes, averages half-pel rows, holds the result beat.
`timescale 1ns / 1ps

module hpfs_merge (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_en,
    input  hpfs_pkg::t_tag                                 i_tag,
    input  logic [hpfs_pkg::NLANES-1:0][hpfs_pkg::PIX_W-1:0] i_bytes,
    output logic                                           o_vld,
    output logic                                           o_status,
    output logic [hpfs_pkg::ROW_W-1:0]                     o_row,
    output logic [63:0]                                    o_pix,
    output logic                                           o_last
);

    logic [hpfs_pkg::BLK:0][hpfs_pkg::PIX_W-1:0] w_cur;
    logic [hpfs_pkg::BLK:0][hpfs_pkg::PIX_W-1:0] r_prev;
    logic [63:0]                                 w_avg;
    logic                                        r_vld;
    logic                                        r_status;
    logic [hpfs_pkg::ROW_W-1:0]                  r_row;
    logic [63:0]                                 r_pix;
    logic                                        r_last;

    // Rotate the sixteen bank bytes so the row's first byte lands at 0
    always_comb begin
        for (int i = 0; i <= hpfs_pkg::BLK; i++) begin
            w_cur[i] = i_bytes[i_tag.rot + hpfs_pkg::LANE_W'(i)];
        end
    end

    // Average each pixel with right neighbour and/or the row below, rounded
    always_comb begin
        logic [9:0] s2;
        logic [9:0] s4;
        s2 = '0;
        s4 = '0;
        w_avg = '0;
        for (int i = 0; i < hpfs_pkg::BLK; i++) begin
            s4 = 10'(r_prev[i]) + 10'(r_prev[i+1]) + 10'(w_cur[i]) + 10'(w_cur[i+1]) + 10'd2;
            case ({i_tag.hx, i_tag.hy})
                2'b00: w_avg[8*i +: 8] = r_prev[i];
                2'b01: begin
                    s2 = 10'(r_prev[i]) + 10'(w_cur[i]) + 10'd1;
                    w_avg[8*i +: 8] = s2[8:1];
                end
                2'b10: begin
                    s2 = 10'(r_prev[i]) + 10'(r_prev[i+1]) + 10'd1;
                    w_avg[8*i +: 8] = s2[8:1];
                end
                default: w_avg[8*i +: 8] = s4[9:2];
            endcase
        end
    end

    // Keep the last fetched row for the next vertical average
    always_ff @(posedge i_clk) begin
        if (i_en && i_tag.vld && i_tag.fetch) begin
            r_prev <= w_cur;
        end
    end

    // Result register: advance when empty or taken, hold otherwise
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_tag.vld && (i_tag.emit || i_tag.direct);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_tag.vld && (i_tag.emit || i_tag.direct)) begin
            r_status <= i_tag.status;
            r_row    <= i_tag.row;
            r_last   <= i_tag.last;
            r_pix    <= i_tag.direct ? 64'd0 : w_avg;
        end
    end

    assign o_vld    = r_vld;
    assign o_status = r_status;
    assign o_row    = r_row;
    assign o_pix    = r_pix;
    assign o_last   = r_last;

endmodule

[rtl/halfpel_block_frame_store.sv]
// Top level of the half-pel block frame store: command sequencer, byte banks, merge.
//
//  channel    dir  beat
//  i_item     in   operation, x_pos, y_pos, half_x, half_y, field_select, row_index, row_pixels
//  o_result   out  status, out_row, out_pixels, last
//  i_cfg_*    in   write enable, register index, 10-bit data (frame_width, frame_height)
//
// One command at a time. Every command but code 3 passes a multiply state; a frame read
// then makes nine row fetches through the sixteen byte-bank read ports, a field read
// five, and a write or a rejected command issues one beat. Code 3 is accepted in idle.
// Reset clears the sequencer, the configuration registers and the result valid flag; the store
// itself is not cleared. A stalled result beat freezes fetch, bank reads and merge.
`timescale 1ns / 1ps

module halfpel_block_frame_store #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    hpfs_in_if.sink                           i_item,
    hpfs_out_if.source                        o_result,
    input  logic                              i_cfg_we,
    input  logic [hpfs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [hpfs_pkg::DIM_W-1:0]        i_cfg_wdata
);

    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
    localparam int BANK_DEPTH = (DEPTH + hpfs_pkg::NLANES - 1) / hpfs_pkg::NLANES;
    localparam int IDX_W      = $clog2(BANK_DEPTH);
    localparam int DEP_W      = $clog2(DEPTH) + 1;
    localparam int PW         = (DEP_W > hpfs_pkg::ADDR_W) ? DEP_W : hpfs_pkg::ADDR_W;

    hpfs_pkg::t_state r_state, n_state;
    hpfs_pkg::t_op    r_op;
    logic [hpfs_pkg::DIM_W-1:0]   r_fw, r_fh;
    logic [PW-1:0]                r_limit;
    logic [8:0]                   r_x;
    logic [hpfs_pkg::DIM_W-1:0]   r_ym;
    logic                         r_hx, r_hy, r_reject;
    logic [hpfs_pkg::ROW_W-1:0]   r_ri;
    logic [63:0]                  r_data;
    logic [hpfs_pkg::ADDR_W-1:0]  r_addr;
    logic [hpfs_pkg::DIM_W:0]     r_stride;
    logic [hpfs_pkg::CNT_W-1:0]   r_cnt;
    hpfs_pkg::t_tag               r_s1_tag;

    logic                         w_en, w_accept, w_reject, w_rd_en, w_wr_en, w_step;
    logic [hpfs_pkg::DIM_W-1:0]   w_ym;
    logic [19:0]                  w_prod, w_area;
    logic [hpfs_pkg::CNT_W-1:0]   w_cnt_last;
    logic [hpfs_pkg::CNT_W-1:0]   w_cnt_m1;
    hpfs_pkg::t_tag               w_tag;
    logic [hpfs_pkg::NLANES-1:0][hpfs_pkg::PIX_W-1:0] w_bytes;
    logic [PW-1:0]                w_base;
    logic                         w_out_vld;

    // Pipeline advances when the result register is free or being taken
    assign w_en     = !w_out_vld || o_result.ready;
    assign w_accept = i_item.valid && i_item.ready;

    // Bounds check and row multiplier operand, taken from the raw beat
    always_comb begin
        w_reject = i_item.x_pos[9] || i_item.y_pos[9]
                || ({2'b0, i_item.x_pos[8:0]} + 11'd8 > {1'b0, r_fw})
                || ({2'b0, i_item.y_pos[8:0]} + 11'd8 > {1'b0, r_fh});
        case (hpfs_pkg::t_op'(i_item.operation))
            hpfs_pkg::OP_WRITE: w_ym = 10'(i_item.y_pos[8:0]) + 10'(i_item.row_index);
            hpfs_pkg::OP_FIELD: w_ym = {i_item.y_pos[8:0], i_item.field_select};
            default:            w_ym = 10'(i_item.y_pos[8:0]);
        endcase
    end

    assign w_prod     = 20'(r_ym) * 20'(r_fw);
    assign w_area     = 20'(r_fw) * 20'(r_fh);
    assign w_cnt_last = (r_op == hpfs_pkg::OP_FIELD) ? hpfs_pkg::FIELD_LAST_CNT
                                                     : hpfs_pkg::FRAME_LAST_CNT;
    assign w_cnt_m1   = r_cnt - 4'd1;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            hpfs_pkg::ST_IDLE: begin
                if (w_accept && hpfs_pkg::t_op'(i_item.operation) != hpfs_pkg::OP_NONE) begin
                    n_state = hpfs_pkg::ST_MUL;
                end
            end
            hpfs_pkg::ST_MUL: n_state = hpfs_pkg::ST_ISSUE;
            hpfs_pkg::ST_ISSUE: begin
                if (w_en && (r_reject || r_op == hpfs_pkg::OP_WRITE || r_cnt == w_cnt_last)) begin
                    n_state = hpfs_pkg::ST_IDLE;
                end
            end
            default: n_state = hpfs_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs: bank strobes and the tag for the next stage
    always_comb begin
        i_item.ready = 1'b0;
        w_rd_en      = 1'b0;
        w_wr_en      = 1'b0;
        w_step       = 1'b0;
        w_tag        = '0;
        w_tag.hx     = r_hx;
        w_tag.hy     = r_hy;
        w_tag.rot    = r_addr[hpfs_pkg::LANE_W-1:0];
        case (r_state)
            hpfs_pkg::ST_IDLE: i_item.ready = 1'b1;
            hpfs_pkg::ST_ISSUE: begin
                if (r_reject) begin
                    w_tag.vld    = 1'b1;
                    w_tag.direct = 1'b1;
                    w_tag.status = 1'b1;
                    w_tag.last   = 1'b1;
                end else if (r_op == hpfs_pkg::OP_WRITE) begin
                    w_wr_en      = w_en;
                    w_tag.vld    = 1'b1;
                    w_tag.direct = 1'b1;
                    w_tag.row    = r_ri;
                    w_tag.last   = 1'b1;
                end else begin
                    w_rd_en      = w_en;
                    w_step       = w_en;
                    w_tag.vld    = 1'b1;
                    w_tag.fetch  = 1'b1;
                    w_tag.emit   = (r_cnt != '0);
                    w_tag.last   = (r_cnt == w_cnt_last);
                    w_tag.row    = (r_op == hpfs_pkg::OP_FIELD) ? {w_cnt_m1[1:0], 1'b0}
                                                                : w_cnt_m1[2:0];
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= hpfs_pkg::ST_IDLE;
            r_fw     <= '0;
            r_fh     <= '0;
            r_s1_tag <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    hpfs_pkg::CFG_FRAME_WIDTH:  r_fw <= i_cfg_wdata;
                    hpfs_pkg::CFG_FRAME_HEIGHT: r_fh <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (w_en) begin
                r_s1_tag <= w_tag;
            end
        end
    end

    // Command capture, base address, row stepping
    always_ff @(posedge i_clk) begin
        r_limit <= ({{(PW-20){1'b0}}, w_area} < PW'(DEPTH)) ? {{(PW-20){1'b0}}, w_area}
                                                            : PW'(DEPTH);
        if (w_accept) begin
            r_op     <= hpfs_pkg::t_op'(i_item.operation);
            r_x      <= i_item.x_pos[8:0];
            r_ym     <= w_ym;
            r_hx     <= i_item.half_x;
            r_hy     <= i_item.half_y;
            r_ri     <= i_item.row_index;
            r_data   <= i_item.row_pixels;
            r_reject <= w_reject;
        end
        if (r_state == hpfs_pkg::ST_MUL) begin
            r_addr   <= hpfs_pkg::ADDR_W'(r_x) + hpfs_pkg::ADDR_W'(w_prod);
            r_stride <= (r_op == hpfs_pkg::OP_FIELD) ? {r_fw, 1'b0} : {1'b0, r_fw};
            r_cnt    <= '0;
        end else if (w_step) begin
            r_addr   <= r_addr + hpfs_pkg::ADDR_W'(r_stride);
            r_cnt    <= r_cnt + 4'd1;
        end
    end

    assign w_base = PW'(r_addr);

    // Sixteen byte banks, interleaved on the low address bits
    for (genvar g = 0; g < hpfs_pkg::NLANES; g++) begin : g_lane
        hpfs_lane #(
            .LANE       (g),
            .DEPTH      (DEPTH),
            .BANK_DEPTH (BANK_DEPTH),
            .IDX_W      (IDX_W),
            .PW         (PW)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rd_en (w_rd_en),
            .i_wr_en (w_wr_en),
            .i_base  (w_base),
            .i_rot   (r_addr[hpfs_pkg::LANE_W-1:0]),
            .i_wdata (r_data),
            .i_limit (r_limit),
            .o_byte  (w_bytes[g])
        );
    end

    hpfs_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_tag    (r_s1_tag),
        .i_bytes  (w_bytes),
        .o_vld    (w_out_vld),
        .o_status (o_result.status),
        .o_row    (o_result.out_row),
        .o_pix    (o_result.out_pixels),
        .o_last   (o_result.last)
    );

    assign o_result.valid = w_out_vld;

`ifndef SYNTH
    // A rejected command gives a single empty beat
    a_reject_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.status) |-> (o_result.last && o_result.out_pixels == 64'd0))
        else $error("rejected command beat is not a single empty beat");

    // Any real command moves to the multiply cycle
    a_accept_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_item.operation != hpfs_pkg::OP_NONE) |=> (r_state == hpfs_pkg::ST_MUL))
        else $error("accepted command did not start");

    // Row counter stays within nine fetches
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hpfs_pkg::ST_ISSUE) |-> (r_cnt <= hpfs_pkg::FRAME_LAST_CNT))
        else $error("row fetch counter overran");

    // Bank writes only while issuing a write command
    a_write_scope: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> (r_state == hpfs_pkg::ST_ISSUE && r_op == hpfs_pkg::OP_WRITE && !r_reject))
        else $error("bank write outside a write command");
`endif

endmodule
